// ===== hw/rtl/etfd_pkg.sv =====
// ----------------------------------------------------------------------------
// etfd_pkg
// Types, codes and reset constants of the edge timing frame decoder.
// ----------------------------------------------------------------------------
package etfd_pkg;

   localparam int unsigned FRAME_BYTES_DEF = 5;
   localparam int unsigned OUT_BYTES       = 5;
   localparam int unsigned TIME_W          = 32;
   localparam int unsigned CSR_W           = 8;

   localparam logic [CSR_W-1:0] BIT_THRESHOLD_RST = 8'd100;
   localparam logic [CSR_W-1:0] GAP_CLAMP_RST     = 8'd140;

   // register indexes of the configuration port
   localparam logic CSR_BIT_THRESHOLD = 1'b0;
   localparam logic CSR_GAP_CLAMP     = 1'b1;

   // request kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_EDGE  = 1'b1;

   // response status
   localparam logic STATUS_FRAME     = 1'b0;
   localparam logic STATUS_LATE_EDGE = 1'b1;

   typedef enum logic [4:0] {
      PH_READY  = 5'b00001,
      PH_START  = 5'b00010,
      PH_WARMUP = 5'b00100,
      PH_DATA   = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic              kind;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [7:0] byte4;
   } rsp_type;

endpackage

// ===== hw/rtl/edge_timing_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// edge_timing_frame_decoder_core
// Decodes a single-wire sensor frame from edge timestamps, MSB first.
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  req      | req_valid, req_ready, req_data   | in
//  rsp      | rsp_valid, rsp_ready, rsp_data   | out
//  csr      | csr_we, csr_index, csr_wdata     | in
//
//  One transaction per cycle while no response stalls: gap subtract, threshold
//  and clamp compares and the bit shift are combinational between the state
//  registers and the response register; a response is valid the cycle after
//  the request that produces it. A new request is taken while the response
//  register is empty or being drained; a stalled response holds off every
//  request. Reset (synchronous) puts the decoder in the done phase with bit
//  threshold 100, gap clamp 140 and an empty response register.
// ----------------------------------------------------------------------------
module edge_timing_frame_decoder_core
   import etfd_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int unsigned FRAME_BITS = FRAME_BYTES * 8;
   localparam int unsigned CNT_W      = $clog2(FRAME_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS);

   logic [CSR_W-1:0]      threshold_ff, threshold_in;
   logic [CSR_W-1:0]      clamp_ff, clamp_in;
   phase_type             phase_ff, phase_in;
   logic [TIME_W-1:0]     last_ff, last_in;
   logic [FRAME_BITS-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  emit;
   logic [TIME_W-1:0]     gap;
   logic                  data_bit;
   logic [FRAME_BITS-1:0] shifted;
   logic [CNT_W-1:0]      count_inc;
   logic [7:0]            frame_byte [OUT_BYTES];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign gap       = req_data.time_us - last_ff;
   assign data_bit  = (gap >= TIME_W'(threshold_ff));
   assign shifted   = {bits_ff[FRAME_BITS-2:0], data_bit};
   assign count_inc = count_ff + CNT_W'(1);

   // bytes beyond the frame length read as zero
   for (genvar k = 0; k < OUT_BYTES; k++) begin : g_byte
      if (k < FRAME_BYTES) begin : g_used
         assign frame_byte[k] = shifted[8*(FRAME_BYTES-1-k) +: 8];
      end else begin : g_unused
         assign frame_byte[k] = 8'd0;
      end
   end

   always_comb begin
      threshold_in = threshold_ff;
      clamp_in     = clamp_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BIT_THRESHOLD: threshold_in = csr_wdata;
            CSR_GAP_CLAMP:     clamp_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      last_in  = last_ff;
      bits_in  = bits_ff;
      count_in = count_ff;
      emit     = 1'b0;
      rsp_in   = rsp_ff;
      if (accept) begin
         if (req_data.kind == KIND_START) begin
            phase_in = PH_READY;
            last_in  = req_data.time_us;
            bits_in  = '0;
            count_in = '0;
         end else begin
            case (phase_ff)
               PH_READY: begin
                  phase_in = PH_START;
                  last_in  = req_data.time_us;
               end
               PH_START: begin
                  phase_in = PH_WARMUP;
                  last_in  = req_data.time_us;
               end
               PH_WARMUP: begin
                  phase_in = PH_DATA;
                  last_in  = req_data.time_us;
               end
               PH_DATA: begin
                  bits_in  = shifted;
                  count_in = count_inc;
                  // credit at most the clamp toward the last edge time
                  if (gap > TIME_W'(clamp_ff)) begin
                     last_in = last_ff + TIME_W'(clamp_ff);
                  end else begin
                     last_in = req_data.time_us;
                  end
                  if (count_inc == CNT_LAST) begin
                     phase_in      = PH_DONE;
                     emit          = 1'b1;
                     rsp_in.status = STATUS_FRAME;
                     rsp_in.byte0  = frame_byte[0];
                     rsp_in.byte1  = frame_byte[1];
                     rsp_in.byte2  = frame_byte[2];
                     rsp_in.byte3  = frame_byte[3];
                     rsp_in.byte4  = frame_byte[4];
                  end
               end
               default: begin
                  phase_in = PH_DONE;
                  last_in  = req_data.time_us;
                  emit     = 1'b1;
                  rsp_in   = '0;
                  rsp_in.status = STATUS_LATE_EDGE;
               end
            endcase
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= BIT_THRESHOLD_RST;
         clamp_ff     <= GAP_CLAMP_RST;
         phase_ff     <= PH_DONE;
         last_ff      <= '0;
         bits_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         clamp_ff     <= clamp_in;
         phase_ff     <= phase_in;
         last_ff      <= last_in;
         bits_ff      <= bits_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_LAST)
      else $error("bit count beyond frame length");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_START |=>
         phase_ff == PH_READY && count_ff == '0 && !$rose(rsp_valid_ff))
      else $error("start transaction did not clear the frame");

   a_late_edge: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_EDGE && phase_ff == PH_DONE |=>
         rsp_valid_ff && rsp_ff.status == STATUS_LATE_EDGE)
      else $error("edge while done gave no error response");

   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_EDGE && phase_ff == PH_DATA &&
      count_ff == CNT_LAST - CNT_W'(1) |=>
         rsp_valid_ff && rsp_ff.status == STATUS_FRAME && phase_ff == PH_DONE)
      else $error("last data bit did not complete the frame");

endmodule

// ===== sim/frame_decode_checker.sv =====
// ----------------------------------------------------------------------------
// frame_decode_checker
// Watches the request, response and register ports of the edge timing frame
// decoder, predicts each completed frame or late-edge error from the accepted
// requests and compares every response field against the oldest prediction.
// ----------------------------------------------------------------------------
module frame_decode_checker
   import etfd_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               pending,
   output int               mismatches
);

   logic [CSR_W-1:0]  threshold_us;
   logic [CSR_W-1:0]  clamp_us;
   phase_type         decode_phase;
   logic [TIME_W-1:0] last_time;
   logic [63:0]       frame_shift;
   int                bit_count;

   rsp_type expected_frames [$];

   assign pending = expected_frames.size();

   function automatic bit predict_decode(input req_type item, output rsp_type frame);
      logic [TIME_W-1:0] gap;
      logic [7:0]        octets [OUT_BYTES];
      logic              data_bit;
      frame = '0;
      if (item.kind == KIND_START) begin
         frame_shift  = '0;
         bit_count    = 0;
         last_time    = item.time_us;
         decode_phase = PH_READY;
         return 1'b0;
      end
      gap = item.time_us - last_time;
      case (decode_phase)
         PH_READY: begin
            decode_phase = PH_START;
            last_time    = item.time_us;
            return 1'b0;
         end
         PH_START: begin
            decode_phase = PH_WARMUP;
            last_time    = item.time_us;
            return 1'b0;
         end
         PH_WARMUP: begin
            decode_phase = PH_DATA;
            last_time    = item.time_us;
            return 1'b0;
         end
         PH_DATA: begin
            data_bit    = (gap < {24'd0, threshold_us}) ? 1'b0 : 1'b1;
            frame_shift = {frame_shift[62:0], data_bit};
            bit_count++;
            // a long gap only credits the clamp, so the recorded time lags
            if (gap > {24'd0, clamp_us})
               last_time = last_time + {24'd0, clamp_us};
            else
               last_time = item.time_us;
            if (bit_count < int'(FRAME_BYTES) * 8)
               return 1'b0;
            decode_phase = PH_DONE;
            for (int k = 0; k < OUT_BYTES; k++) begin
               if (k < int'(FRAME_BYTES))
                  octets[k] = 8'(frame_shift >> (8 * (int'(FRAME_BYTES) - 1 - k)));
               else
                  octets[k] = 8'd0;
            end
            frame.status = STATUS_FRAME;
            frame.byte0  = octets[0];
            frame.byte1  = octets[1];
            frame.byte2  = octets[2];
            frame.byte3  = octets[3];
            frame.byte4  = octets[4];
            return 1'b1;
         end
         default: begin
            decode_phase = PH_DONE;
            last_time    = item.time_us;
            frame.status = STATUS_LATE_EDGE;
            return 1'b1;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         threshold_us = BIT_THRESHOLD_RST;
         clamp_us     = GAP_CLAMP_RST;
         decode_phase = PH_DONE;
         last_time    = '0;
         frame_shift  = '0;
         bit_count    = 0;
         expected_frames.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BIT_THRESHOLD: threshold_us = csr_wdata;
               CSR_GAP_CLAMP:     clamp_us     = csr_wdata;
               default: ;
            endcase
         end
         // the response is registered, so compare before taking a request
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               mismatches++;
               $display("%0t: response with nothing expected, expected none, got %h",
                        $time, rsp_data);
            end else begin
               want = expected_frames.pop_front();
               check_field("status", {7'd0, want.status}, {7'd0, rsp_data.status});
               check_field("byte0", want.byte0, rsp_data.byte0);
               check_field("byte1", want.byte1, rsp_data.byte1);
               check_field("byte2", want.byte2, rsp_data.byte2);
               check_field("byte3", want.byte3, rsp_data.byte3);
               check_field("byte4", want.byte4, rsp_data.byte4);
            end
         end
         if (req_valid && req_ready) begin
            if (predict_decode(req_data, fresh))
               expected_frames.push_back(fresh);
         end
      end
   end

endmodule

// ===== sim/edge_timing_frame_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// edge_timing_frame_decoder_core_test
// Drives start and edge requests into the frame decoder: a short directed run
// through the phases and timing corners, then random frames, broken frames and
// noise under several threshold and clamp settings, with random request gaps
// and response stalls. The checker beside the block predicts and compares the responses.
// ----------------------------------------------------------------------------
module edge_timing_frame_decoder_core_test;
   import etfd_pkg::*;

   localparam int ITEM_TARGET    = 1550;
   localparam int SETTING_COUNT  = 7;
   localparam int WATCHDOG_LIMIT = 1000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we    = 1'b0;
   logic             csr_index = CSR_BIT_THRESHOLD;
   logic [CSR_W-1:0] csr_wdata = '0;

   int pending;
   int mismatches;
   int items_sent   = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;
   bit no_idle      = 1'b0;

   logic [TIME_W-1:0] now_us;
   logic [CSR_W-1:0]  threshold = BIT_THRESHOLD_RST;
   logic [CSR_W-1:0]  clamp     = GAP_CLAMP_RST;

   logic [CSR_W-1:0] threshold_set [SETTING_COUNT] = '{8'd1, 8'd255, 8'd0, 8'd255, 8'd1,
                                                       8'd100, 8'd60};
   logic [CSR_W-1:0] clamp_set     [SETTING_COUNT] = '{8'd1, 8'd255, 8'd0, 8'd1, 8'd255,
                                                       8'd140, 8'd90};

   always #5 clock = ~clock;

   edge_timing_frame_decoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_decode_checker decode_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .mismatches (mismatches)
   );

   // mostly short pauses, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(1, 2);
      else if (r < 92)
         return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic int send_gap();
      if (no_idle || $urandom_range(0, 1) == 0)
         return 0;
      return idle_len();
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 3) == 0)
            stall_left = idle_len();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(input logic kind, input logic [TIME_W-1:0] stamp);
      int gap;
      req_data  <= '{kind: kind, time_us: stamp};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
      gap = send_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic start_at(input logic [TIME_W-1:0] stamp);
      now_us = stamp;
      send_item(KIND_START, now_us);
   endtask

   task automatic edge_after(input logic [TIME_W-1:0] delta);
      now_us = now_us + delta;
      send_item(KIND_EDGE, now_us);
   endtask

   // hold requests until every predicted response has drained
   task automatic drain_responses();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [CSR_W-1:0] thr, input logic [CSR_W-1:0] clm);
      csr_we    <= 1'b1;
      csr_index <= CSR_BIT_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= CSR_GAP_CLAMP;
      csr_wdata <= clm;
      @(posedge clock);
      csr_we    <= 1'b0;
      threshold = thr;
      clamp     = clm;
   endtask

   function automatic logic [TIME_W-1:0] data_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return $urandom_range(0, threshold);
      else if (r < 80)
         return $urandom_range(threshold, 255);
      else if (r < 90) begin
         case ($urandom_range(0, 3))
            0:       return {24'd0, threshold} - 1;
            1:       return {24'd0, threshold};
            2:       return {24'd0, clamp};
            default: return {24'd0, clamp} + 1;
         endcase
      end else if (r < 95)
         return $urandom_range(256, 5000);
      return $urandom();
   endfunction

   function automatic logic [TIME_W-1:0] warmup_delta();
      if ($urandom_range(0, 9) == 0)
         return $urandom();
      return $urandom_range(10, 200);
   endfunction

   task automatic random_frame(input bit complete);
      int edges;
      if ($urandom_range(0, 3) == 0)
         start_at(32'hFFFF_FFFF - $urandom_range(0, 3000));
      else
         start_at($urandom());
      edges = complete ? 43 : $urandom_range(0, 42);
      for (int i = 0; i < edges; i++)
         edge_after(i < 3 ? warmup_delta() : data_delta());
      if (complete) begin
         repeat ($urandom_range(0, 2)) edge_after($urandom_range(0, 500));
      end
   endtask

   initial begin
      int phase_end;
      int frames;
      int pick;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // edges straight out of reset land in the done phase
      send_item(KIND_EDGE, 32'hFFFF_FFFF);
      send_item(KIND_EDGE, 32'h0000_0000);
      start_at(32'hFFFF_FF80);
      edge_after(50);
      // restart before the warmup, then walk into data across the time wrap
      start_at(32'hFFFF_FFC0);
      edge_after(30);
      edge_after(80);
      edge_after(50);
      edge_after(99);
      edge_after(100);
      edge_after(140);
      edge_after(141);
      edge_after(0);
      edge_after(32'hFFFF_FFFF);
      edge_after(32'h8000_0000);
      edge_after(255);
      // restart in the middle of the data bits
      start_at(32'h0000_0000);
      edge_after(1);
      edge_after(1);
      edge_after(1);
      edge_after(0);
      drain_responses();

      for (int s = 0; s < SETTING_COUNT; s++) begin
         write_settings(threshold_set[s], clamp_set[s]);
         phase_end = 20 + ITEM_TARGET * (s + 1) / SETTING_COUNT;
         frames    = 0;
         while (items_sent < phase_end || frames < 6) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0)
               drain_responses();
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               random_frame(1'b1);
               frames++;
            end else if (pick < 9)
               random_frame(1'b0);
            else begin
               repeat ($urandom_range(1, 5)) begin
                  now_us = $urandom();
                  send_item($urandom_range(0, 1) == 0 ? KIND_START : KIND_EDGE, now_us);
               end
            end
         end
         drain_responses();
      end

      no_idle = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/etfd_pkg.sv
hw/rtl/edge_timing_frame_decoder_core.sv
sim/frame_decode_checker.sv
sim/edge_timing_frame_decoder_core_test.sv
